### design/q2e_pkg.sv
// ----------------------------------------------------------------------------
// q2e_pkg
// Types, widths and constants for the quaternion to Euler angle converter.
// ----------------------------------------------------------------------------
package q2e_pkg;

    localparam int SUM_W  = 38;
    localparam int LANE_W = 40;
    localparam int ANG_W  = 36;
    localparam int ROOT_W = 31;
    localparam int REM_W  = 36;
    localparam int RAD_W  = 62;
    localparam int DEG_W  = 22;
    localparam int NUM_LANES = 3;
    localparam int LANE_PITCH = 0;
    localparam int LANE_ROLL  = 1;
    localparam int LANE_YAW   = 2;

    localparam logic signed [SUM_W-1:0] Q30_ONE     = 38'sd1073741824;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic [28:0]             DIV10_RECIP = 29'd429496730;

    typedef struct packed {
        logic signed [SUM_W-1:0] ry;
        logic signed [SUM_W-1:0] rx;
        logic signed [SUM_W-1:0] yy;
        logic signed [SUM_W-1:0] yx;
    } rpy_ops_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  rad;
        logic signed [31:0] s;
        rpy_ops_t          ops;
    } sqrt_stage_t;

    typedef struct packed {
        logic signed [LANE_W-1:0] x;
        logic signed [LANE_W-1:0] y;
        logic signed [ANG_W-1:0]  z;
        logic                     zero;
    } cordic_lane_t;

    function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
        case (idx)
            0:  return 36'sd843314857;
            1:  return 36'sd497837830;
            2:  return 36'sd263043837;
            3:  return 36'sd133525159;
            4:  return 36'sd67021687;
            5:  return 36'sd33543516;
            6:  return 36'sd16775851;
            7:  return 36'sd8388438;
            8:  return 36'sd4194283;
            9:  return 36'sd2097149;
            10: return 36'sd1048576;
            11: return 36'sd524288;
            12: return 36'sd262144;
            13: return 36'sd131072;
            14: return 36'sd65536;
            15: return 36'sd32768;
            16: return 36'sd16384;
            17: return 36'sd8192;
            18: return 36'sd4096;
            19: return 36'sd2048;
            20: return 36'sd1024;
            21: return 36'sd512;
            22: return 36'sd256;
            23: return 36'sd128;
            24: return 36'sd64;
            25: return 36'sd32;
            26: return 36'sd16;
            27: return 36'sd8;
            28: return 36'sd4;
            29: return 36'sd2;
            default: return 36'sd0;
        endcase
    endfunction

endpackage

### design/quaternion_to_euler_angles.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Pipelined conversion of a Q30 quaternion to pitch, roll, yaw and heading.
// ----------------------------------------------------------------------------
// channel   dir  tdata (lowest bit up)
// s_axis    in   quat_w[31:0] quat_x[63:32] quat_y[95:64] quat_z[127:96]
// m_axis    out  pitch[13:0] roll[28:14] yaw[43:29] heading[58:44], zero pad
//
// One request enters per cycle while the output is not stalled; the pipeline
// holds the 31 digit stages of the square root and then the CORDIC stages.
// Reset clears only the valid bits. A stall at the output holds every stage
// at once; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles #(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 6
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata    // pitch_angle, roll_angle, yaw_angle, heading_angle
);

    localparam int NSQ   = 31;
    localparam int NST   = 40 + CORDIC_STEPS;
    localparam int NW    = 44 + ANGLE_FRAC_BITS;
    localparam int TW    = NW - 30;
    localparam int PW    = TW + 29;
    localparam int QW    = PW - 32;
    localparam int LIM_P = (5762 << ANGLE_FRAC_BITS) >> 6;
    localparam int LIM_R = (11523 << ANGLE_FRAC_BITS) >> 6;
    localparam int HEAD_FULL = 360 << ANGLE_FRAC_BITS;

    logic            en;
    logic [NST-1:0]  vld_reg;

    logic signed [31:0] qw, qx, qy, qz;
    logic signed [63:0] wy_reg, xz_reg, yz_reg, wx_reg, xx_reg;
    logic signed [63:0] yy_reg, xy_reg, wz_reg, ww_reg, zz_reg;

    logic signed [q2e_pkg::SUM_W-1:0] s2_s_reg;
    q2e_pkg::rpy_ops_t                s2_ops_reg;
    logic signed [q2e_pkg::SUM_W-1:0] s3_clamp;
    logic signed [31:0]               s3_s_reg;
    logic [63:0]                      s3_sq_reg;
    q2e_pkg::rpy_ops_t                s3_ops_reg;

    q2e_pkg::sqrt_stage_t  sq_reg [0:NSQ];
    q2e_pkg::cordic_lane_t cr_reg [0:CORDIC_STEPS][0:q2e_pkg::NUM_LANES-1];

    logic [43:0]                      pm_reg   [0:q2e_pkg::NUM_LANES-1];
    logic [q2e_pkg::NUM_LANES-1:0]    nega_reg;
    logic [PW-1:0]                    prod_reg [0:q2e_pkg::NUM_LANES-1];
    logic [q2e_pkg::NUM_LANES-1:0]    negb_reg;
    logic signed [q2e_pkg::DEG_W-1:0] ang_reg  [0:q2e_pkg::NUM_LANES-1];

    logic [13:0] pitch_reg;
    logic [14:0] roll_reg, yaw_reg, head_reg;

    function automatic logic signed [q2e_pkg::SUM_W-1:0] q30(input logic signed [63:0] p);
        return q2e_pkg::SUM_W'($signed(p[63:30]));
    endfunction

    function automatic q2e_pkg::cordic_lane_t prerot(input logic signed [q2e_pkg::LANE_W-1:0] y,
                                                     input logic signed [q2e_pkg::LANE_W-1:0] x);
        q2e_pkg::cordic_lane_t r;
        r.zero = (x == '0) && (y == '0);
        r.x    = x;
        r.y    = y;
        r.z    = '0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                r.x = y;
                r.y = -x;
                r.z = q2e_pkg::HALF_PI_Q30;
            end
            else
            begin
                r.x = -y;
                r.y = x;
                r.z = -q2e_pkg::HALF_PI_Q30;
            end
        end
        return r;
    endfunction

    function automatic q2e_pkg::cordic_lane_t rotate(input q2e_pkg::cordic_lane_t a, input int i);
        q2e_pkg::cordic_lane_t     r;
        logic signed [q2e_pkg::LANE_W-1:0] xv, yv, xs, ys;
        xv = a.x;
        yv = a.y;
        xs = xv >>> i;
        ys = yv >>> i;
        r.zero = a.zero;
        if (yv > 0)
        begin
            r.x = xv + ys;
            r.y = yv - xs;
            r.z = a.z + q2e_pkg::atan_entry(i);
        end
        else
        begin
            r.x = xv - ys;
            r.y = yv + xs;
            r.z = a.z - q2e_pkg::atan_entry(i);
        end
        return r;
    endfunction

    assign en       = m_tready | ~vld_reg[NST-1];
    assign s_tready = en;
    assign m_tvalid = vld_reg[NST-1];
    assign m_tdata  = {5'b0, head_reg, yaw_reg, roll_reg, pitch_reg};

    assign qw = $signed(s_tdata[31:0]);
    assign qx = $signed(s_tdata[63:32]);
    assign qy = $signed(s_tdata[95:64]);
    assign qz = $signed(s_tdata[127:96]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NST-2:0], s_tvalid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wy_reg <= qw * qy;
            xz_reg <= qx * qz;
            yz_reg <= qy * qz;
            wx_reg <= qw * qx;
            xx_reg <= qx * qx;
            yy_reg <= qy * qy;
            xy_reg <= qx * qy;
            wz_reg <= qw * qz;
            ww_reg <= qw * qw;
            zz_reg <= qz * qz;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_s_reg      <= (q30(wy_reg) - q30(xz_reg)) <<< 1;
            s2_ops_reg.ry <= (q30(yz_reg) + q30(wx_reg)) <<< 1;
            s2_ops_reg.rx <= q2e_pkg::Q30_ONE - ((q30(xx_reg) + q30(yy_reg)) <<< 1);
            s2_ops_reg.yy <= (q30(xy_reg) + q30(wz_reg)) <<< 1;
            s2_ops_reg.yx <= q30(ww_reg) + q30(xx_reg) - q30(yy_reg) - q30(zz_reg);
        end
    end

    always_comb
    begin
        if (s2_s_reg > q2e_pkg::Q30_ONE)
            s3_clamp = q2e_pkg::Q30_ONE;
        else if (s2_s_reg < -q2e_pkg::Q30_ONE)
            s3_clamp = -q2e_pkg::Q30_ONE;
        else
            s3_clamp = s2_s_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_s_reg   <= s3_clamp[31:0];
            s3_sq_reg  <= 64'($signed(s3_clamp[31:0])) * 64'($signed(s3_clamp[31:0]));
            s3_ops_reg <= s2_ops_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg[0].rem  <= '0;
            sq_reg[0].root <= '0;
            sq_reg[0].rad  <= (q2e_pkg::RAD_W'(1) << 60) - s3_sq_reg[q2e_pkg::RAD_W-1:0];
            sq_reg[0].s    <= s3_s_reg;
            sq_reg[0].ops  <= s3_ops_reg;
        end
    end

    for (genvar k = 1; k <= NSQ; k++)
    begin : g_sqrt
        localparam int J = NSQ - k;
        logic [q2e_pkg::REM_W-1:0] rem_sh, trial;
        assign rem_sh = {sq_reg[k-1].rem[q2e_pkg::REM_W-3:0], sq_reg[k-1].rad[2*J +: 2]};
        assign trial  = q2e_pkg::REM_W'({sq_reg[k-1].root, 2'b01});
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_reg[k].rad <= sq_reg[k-1].rad;
                sq_reg[k].s   <= sq_reg[k-1].s;
                sq_reg[k].ops <= sq_reg[k-1].ops;
                if (rem_sh >= trial)
                begin
                    sq_reg[k].rem  <= rem_sh - trial;
                    sq_reg[k].root <= {sq_reg[k-1].root[q2e_pkg::ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    sq_reg[k].rem  <= rem_sh;
                    sq_reg[k].root <= {sq_reg[k-1].root[q2e_pkg::ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cr_reg[0][q2e_pkg::LANE_PITCH] <= prerot(q2e_pkg::LANE_W'(sq_reg[NSQ].s),
                $signed(q2e_pkg::LANE_W'(sq_reg[NSQ].root)));
            cr_reg[0][q2e_pkg::LANE_ROLL]  <= prerot(q2e_pkg::LANE_W'(sq_reg[NSQ].ops.ry),
                q2e_pkg::LANE_W'(sq_reg[NSQ].ops.rx));
            cr_reg[0][q2e_pkg::LANE_YAW]   <= prerot(q2e_pkg::LANE_W'(sq_reg[NSQ].ops.yy),
                q2e_pkg::LANE_W'(sq_reg[NSQ].ops.yx));
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        for (genvar l = 0; l < q2e_pkg::NUM_LANES; l++)
        begin : g_lane
            always_ff @(posedge clk)
            begin
                if (en)
                    cr_reg[i+1][l] <= rotate(cr_reg[i][l], i);
            end
        end
    end

    for (genvar l = 0; l < q2e_pkg::NUM_LANES; l++)
    begin : g_deg
        localparam int LIM = (l == q2e_pkg::LANE_PITCH) ? LIM_P : LIM_R;
        logic signed [q2e_pkg::ANG_W-1:0] za;
        logic [q2e_pkg::ANG_W-1:0]        mag;
        logic [NW-1:0]                    num;
        logic [QW-1:0]                    q;
        logic [31:0]                      qv;
        assign za  = cr_reg[CORDIC_STEPS][l].zero ? '0 : cr_reg[CORDIC_STEPS][l].z;
        assign mag = (za < 0) ? q2e_pkg::ANG_W'(-za) : q2e_pkg::ANG_W'(za);
        assign num = (NW'(pm_reg[l]) << ANGLE_FRAC_BITS) + NW'(64'd5 << 30);
        assign q   = prod_reg[l][PW-1:32];
        assign qv  = (32'(q) > 32'(LIM)) ? 32'(LIM) : 32'(q);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pm_reg[l]   <= 44'(mag[33:0] * 44'd573);
                nega_reg[l] <= (za < 0);
                prod_reg[l] <= PW'(num[NW-1:30]) * PW'(q2e_pkg::DIV10_RECIP);
                negb_reg[l] <= nega_reg[l];
                ang_reg[l]  <= negb_reg[l] ? -$signed(qv[q2e_pkg::DEG_W-1:0])
                                           : $signed(qv[q2e_pkg::DEG_W-1:0]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pitch_reg <= ang_reg[q2e_pkg::LANE_PITCH][13:0];
            roll_reg  <= ang_reg[q2e_pkg::LANE_ROLL][14:0];
            yaw_reg   <= ang_reg[q2e_pkg::LANE_YAW][14:0];
            if (ang_reg[q2e_pkg::LANE_YAW] > 0)
                head_reg <= 15'(q2e_pkg::DEG_W'(HEAD_FULL) - ang_reg[q2e_pkg::LANE_YAW]);
            else
                head_reg <= 15'(-ang_reg[q2e_pkg::LANE_YAW]);
        end
    end

endmodule
